// File: rtl/core/bcd_pkg.sv
// Shared types, codes and defaults of the button click debouncer.
`default_nettype none

package bcd_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int TIME_BITS_DEF   = 32;

    localparam int IDX_W      = 2;
    localparam int NOW_W      = 32;
    localparam int MS_W       = 16;
    localparam int MASK_W     = 4;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int IN_FIELDS_W  = IDX_W + 1 + NOW_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = IDX_W + 1 + 1 + PHASE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [MS_W-1:0]   DEBOUNCE_RST    = 16'd50;
    localparam logic [MS_W-1:0]   PRESS_LIMIT_RST = 16'd3000;
    localparam logic [MASK_W-1:0] ACT_HIGH_RST    = 4'd0;
    localparam logic [MASK_W-1:0] ENABLE_RST      = 4'd15;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_TOO_LONG = 3'd3,
        PH_FINISHED = 3'd4
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE    = 8'd0,
        CFG_PRESS_LIMIT = 8'd1,
        CFG_ACT_HIGH    = 8'd2,
        CFG_ENABLE      = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        t_phase phase;
        logic   pressed;
        logic   evt;
    } t_btn_flags;

    typedef struct packed {
        logic click;
        logic long_press;
        logic set_time;
    } t_step_evt;

endpackage

`default_nettype wire

// File: rtl/core/bcd_step.sv
// Next-state logic of one button's debounce and click machine.
`default_nettype none

module bcd_step
    import bcd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire t_btn_flags            i_cur,
    input  wire logic                  i_active,
    input  wire logic [TIME_BITS-1:0]  i_elapsed,
    input  wire logic [MS_W-1:0]       i_debounce_ms,
    input  wire logic [MS_W-1:0]       i_press_limit_ms,
    output t_btn_flags                 o_nxt,
    output t_step_evt                  o_evt
);

    logic w_deb_done;
    logic w_over_limit;

    assign w_deb_done   = (i_elapsed >= TIME_BITS'(i_debounce_ms));
    assign w_over_limit = (i_elapsed >  TIME_BITS'(i_press_limit_ms));

    always_comb begin
        o_nxt = i_cur;
        o_evt = '0;
        unique case (i_cur.phase)
            PH_IDLE: begin
                if (i_active && !i_cur.pressed) begin
                    o_nxt.phase    = PH_DEBOUNCE;
                    o_evt.set_time = 1'b1;
                end
            end
            PH_DEBOUNCE: begin
                if (!i_active) begin
                    o_nxt.phase = PH_IDLE;
                end else if (w_deb_done && !i_cur.pressed) begin
                    o_nxt.phase   = PH_PRESSED;
                    o_nxt.pressed = 1'b1;
                    o_nxt.evt     = 1'b0;
                end
            end
            PH_PRESSED: begin
                if (i_cur.pressed && !i_cur.evt) begin
                    if (w_over_limit) begin
                        o_nxt.phase      = PH_TOO_LONG;
                        o_evt.long_press = 1'b1;
                    end else if (!i_active) begin
                        o_nxt.phase = PH_FINISHED;
                        o_nxt.evt   = 1'b1;
                    end
                end
            end
            PH_TOO_LONG: begin
                if (!i_active) begin
                    o_nxt.phase    = PH_IDLE;
                    o_nxt.pressed  = 1'b0;
                    o_nxt.evt      = 1'b0;
                    o_evt.set_time = 1'b1;
                end
            end
            PH_FINISHED: begin
                if (i_cur.evt) begin
                    o_nxt.phase    = PH_IDLE;
                    o_nxt.pressed  = 1'b0;
                    o_nxt.evt      = 1'b0;
                    o_evt.click    = 1'b1;
                    o_evt.set_time = 1'b1;
                end
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/button_click_debouncer.sv
// Top level of the button click debouncer with per-button state and stream ports.
`default_nettype none

// Each input item is one poll of one button. It is captured in an input
// register, and once the output register is free the button's state is read,
// advanced and, for an enabled button in range, written back while the single
// result item is loaded into the output register. One item is accepted every
// cycle as long as the output side takes results, since the per-button state
// update completes in the same cycle the item leaves the input register. Time
// differences wrap modulo 2^TIME_BITS. Configuration writes are always taken
// and should be issued only while no item is in flight.

module button_click_debouncer
    import bcd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Fields from bit 0 up: button_index[1:0], level[2], now_ms[34:3], zero fill.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0 up: result_index[1:0], click[2], long_press[3], phase[6:4],
    // zero fill.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [MS_W-1:0]   r_debounce_ms;
    logic [MS_W-1:0]   r_press_limit_ms;
    logic [MASK_W-1:0] r_act_high;
    logic [MASK_W-1:0] r_enable;

    t_btn_flags           r_flags [NUM_BUTTONS];
    logic [TIME_BITS-1:0] r_ctime [NUM_BUTTONS];

    logic             r_in_valid;
    logic [IDX_W-1:0] r_in_idx;
    logic             r_in_level;
    logic [NOW_W-1:0] r_in_now;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_in_range;
    logic                 w_enabled;
    logic                 w_active;
    logic                 w_write;
    logic [BTN_W-1:0]     w_btn;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_elapsed;
    t_btn_flags           w_cur;
    t_btn_flags           w_nxt;
    t_step_evt            w_evt;
    t_phase               w_res_phase;
    logic                 w_click;
    logic                 w_long;
    logic [OUT_TDATA_W-1:0] n_out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms    <= DEBOUNCE_RST;
            r_press_limit_ms <= PRESS_LIMIT_RST;
            r_act_high       <= ACT_HIGH_RST;
            r_enable         <= ENABLE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:    r_debounce_ms    <= i_cfg_data;
                CFG_PRESS_LIMIT: r_press_limit_ms <= i_cfg_data;
                CFG_ACT_HIGH:    r_act_high       <= i_cfg_data[MASK_W-1:0];
                CFG_ENABLE:      r_enable         <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_idx   <= s_axis_tdata[IDX_W-1:0];
            r_in_level <= s_axis_tdata[IDX_W];
            r_in_now   <= s_axis_tdata[IDX_W+NOW_W:IDX_W+1];
        end
    end

    assign w_in_range = (32'(r_in_idx) < NUM_BUTTONS);
    assign w_btn      = BTN_W'(r_in_idx);
    assign w_enabled  = r_enable[r_in_idx];
    assign w_active   = (r_in_level == r_act_high[r_in_idx]);
    assign w_now      = TIME_BITS'(r_in_now);
    assign w_cur      = w_in_range ? r_flags[w_btn] : t_btn_flags'{PH_IDLE, 1'b0, 1'b0};
    assign w_elapsed  = w_now - (w_in_range ? r_ctime[w_btn] : '0);
    assign w_write    = w_advance && w_in_range && w_enabled;

    bcd_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_cur            (w_cur),
        .i_active         (w_active),
        .i_elapsed        (w_elapsed),
        .i_debounce_ms    (r_debounce_ms),
        .i_press_limit_ms (r_press_limit_ms),
        .o_nxt            (w_nxt),
        .o_evt            (w_evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_flags[i] <= '{PH_IDLE, 1'b0, 1'b0};
                r_ctime[i] <= '0;
            end
        end else if (w_write) begin
            r_flags[w_btn] <= w_nxt;
            if (w_evt.set_time) begin
                r_ctime[w_btn] <= w_now;
            end
        end
    end

    always_comb begin
        w_res_phase = w_cur.phase;
        w_click     = 1'b0;
        w_long      = 1'b0;
        if (w_in_range && w_enabled) begin
            w_res_phase = w_nxt.phase;
            w_click     = w_evt.click;
            w_long      = w_evt.long_press;
        end
        n_out_data = OUT_TDATA_W'({w_res_phase, w_long, w_click, r_in_idx});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/core/bcd_checker.sv
// Port-level assertions for the button click debouncer and their bind.
`default_nettype none

module bcd_checker
    import bcd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready
);

    logic                 w_click;
    logic                 w_long;
    logic [PHASE_W-1:0]   w_phase;

    assign w_click = m_axis_tdata[IDX_W];
    assign w_long  = m_axis_tdata[IDX_W+1];
    assign w_phase = m_axis_tdata[IDX_W+2+PHASE_W-1:IDX_W+2];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(w_click && w_long))
        else $error("click and long press in one result");

    a_click_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_click |-> w_phase == PH_IDLE)
        else $error("click reported outside idle phase");

    a_long_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_long |-> w_phase == PH_TOO_LONG)
        else $error("long press reported outside too-long phase");

endmodule

bind button_click_debouncer bcd_checker u_bcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the button click debouncer with stream and register ports.
`timescale 1ns / 1ps

module testbench;
    import bcd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             level;
        logic [NOW_W-1:0] now;
    } t_poll;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             click;
        logic             long_press;
        t_phase           phase;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    button_click_debouncer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Predicted configuration and per-button state.
    logic [MS_W-1:0]   bounce_ms = DEBOUNCE_RST;
    logic [MS_W-1:0]   limit_ms = PRESS_LIMIT_RST;
    logic [MASK_W-1:0] high_mask = ACT_HIGH_RST;
    logic [MASK_W-1:0] on_mask = ENABLE_RST;
    t_phase            btn_phase [NUM_BUTTONS_DEF];
    logic              btn_down [NUM_BUTTONS_DEF];
    logic              btn_evt [NUM_BUTTONS_DEF];
    logic [NOW_W-1:0]  btn_since [NUM_BUTTONS_DEF];

    t_poll    poll_q [$];
    t_outcome outcome_q [$];
    t_poll    cur_poll;
    int       polls_queued = 0;
    int       results_seen = 0;
    int       errors = 0;
    bit       pace_on = 1'b1;
    int       hold_asks = 0;
    int       hold_served = 0;
    int       hold_left = 0;
    int       src_gap = 0;
    int       sink_gap = 0;
    int       quiet_cycles = 0;
    logic     next_valid;
    logic     next_ready;

    // Stimulus planning per button: current timeline, hold level and run length.
    logic [NOW_W-1:0] plan_time [NUM_BUTTONS_DEF];
    bit               plan_hold [NUM_BUTTONS_DEF];
    int               plan_left [NUM_BUTTONS_DEF];

    function automatic t_outcome advance_button(t_poll p);
        t_outcome         r;
        logic             act;
        logic [NOW_W-1:0] elapsed;
        r.idx = p.idx;
        r.click = 1'b0;
        r.long_press = 1'b0;
        r.phase = btn_phase[p.idx];
        if (on_mask[p.idx]) begin
            act = (p.level == high_mask[p.idx]);
            elapsed = p.now - btn_since[p.idx];
            case (r.phase)
                PH_IDLE: begin
                    if (act && !btn_down[p.idx]) begin
                        r.phase = PH_DEBOUNCE;
                        btn_since[p.idx] = p.now;
                    end
                end
                PH_DEBOUNCE: begin
                    if (!act) begin
                        r.phase = PH_IDLE;
                    end else if (elapsed >= {16'd0, bounce_ms} && !btn_down[p.idx]) begin
                        btn_down[p.idx] = 1'b1;
                        btn_evt[p.idx] = 1'b0;
                        r.phase = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (btn_down[p.idx] && !btn_evt[p.idx]) begin
                        if (elapsed > {16'd0, limit_ms}) begin
                            r.phase = PH_TOO_LONG;
                            r.long_press = 1'b1;
                        end else if (!act) begin
                            btn_evt[p.idx] = 1'b1;
                            r.phase = PH_FINISHED;
                        end
                    end
                end
                PH_TOO_LONG: begin
                    if (!act) begin
                        btn_down[p.idx] = 1'b0;
                        btn_evt[p.idx] = 1'b0;
                        btn_since[p.idx] = p.now;
                        r.phase = PH_IDLE;
                    end
                end
                PH_FINISHED: begin
                    if (btn_evt[p.idx]) begin
                        r.click = 1'b1;
                        btn_down[p.idx] = 1'b0;
                        btn_evt[p.idx] = 1'b0;
                        btn_since[p.idx] = p.now;
                        r.phase = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
            btn_phase[p.idx] = r.phase;
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Source side: loads pending polls and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                outcome_q.push_back(advance_button(cur_poll));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (poll_q.size() > 0) begin
                    if (pace_on && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(0, 13);
                    end else begin
                        cur_poll = poll_q.pop_front();
                        s_axis_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}},
                                         cur_poll.now, cur_poll.level, cur_poll.idx};
                        next_valid = 1'b1;
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Sink side: checks every accepted result and paces tready.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("result_index", want.idx, m_axis_tdata[1:0]);
                    check_field("click", want.click, m_axis_tdata[2]);
                    check_field("long_press", want.long_press, m_axis_tdata[3]);
                    check_field("phase", want.phase, m_axis_tdata[6:4]);
                end
            end
            if (hold_asks != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                next_ready = 1'b0;
            end else if (pace_on && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 13);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            m_axis_tready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_poll(int b, logic lvl, logic [NOW_W-1:0] t);
        t_poll p;
        p.idx = IDX_W'(b);
        p.level = lvl;
        p.now = t;
        poll_q.push_back(p);
        polls_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != polls_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx r, logic [CFG_DATA_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (r)
            CFG_DEBOUNCE:    bounce_ms = v;
            CFG_PRESS_LIMIT: limit_ms = v;
            CFG_ACT_HIGH:    high_mask = v[MASK_W-1:0];
            CFG_ENABLE:      on_mask = v[MASK_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic write_all(int dbn, int lim, int ah, int en);
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(dbn));
        write_reg(CFG_PRESS_LIMIT, CFG_DATA_W'(lim));
        write_reg(CFG_ACT_HIGH, CFG_DATA_W'(ah));
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    endtask

    // Mostly press and release runs on per-button timelines, with some noise.
    task automatic queue_presses(int count);
        int          k;
        int          b;
        int unsigned span;
        logic        lvl;
        span = ((bounce_ms > limit_ms) ? bounce_ms : limit_ms) / 2 + 4;
        for (k = 0; k < count; k++) begin
            b = $urandom_range(0, NUM_BUTTONS_DEF - 1);
            if ($urandom_range(0, 9) == 0) begin
                queue_poll(b, 1'($urandom_range(0, 1)), $urandom());
            end else begin
                if (plan_left[b] == 0) begin
                    plan_hold[b] = !plan_hold[b];
                    plan_left[b] = $urandom_range(1, 6);
                end
                plan_left[b]--;
                plan_time[b] += $urandom_range(0, span);
                lvl = plan_hold[b] ? high_mask[b] : !high_mask[b];
                queue_poll(b, lvl, plan_time[b]);
            end
        end
    endtask

    initial begin
        for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
            btn_phase[b] = PH_IDLE;
            btn_down[b] = 1'b0;
            btn_evt[b] = 1'b0;
            btn_since[b] = '0;
            plan_time[b] = (b == 0) ? 32'hFFFF_F000 : $urandom();
            plan_hold[b] = 1'b0;
            plan_left[b] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration, active low: click across the timestamp wrap,
        // long press, release during debouncing.
        queue_poll(0, 1'b1, 32'd100);
        queue_poll(0, 1'b0, 32'hFFFF_FFF0);
        queue_poll(0, 1'b0, 32'hFFFF_FFF0 + 32'd49);
        queue_poll(0, 1'b0, 32'hFFFF_FFF0 + 32'd50);
        queue_poll(0, 1'b1, 32'hFFFF_FFF0 + 32'd3000);
        queue_poll(0, 1'b1, 32'hFFFF_FFF0 + 32'd3100);
        queue_poll(1, 1'b0, 32'd1000);
        queue_poll(1, 1'b0, 32'd1050);
        queue_poll(1, 1'b0, 32'd4001);
        queue_poll(1, 1'b0, 32'd5000);
        queue_poll(1, 1'b1, 32'd5001);
        queue_poll(2, 1'b0, 32'd10);
        queue_poll(2, 1'b1, 32'd20);
        queue_poll(3, 1'b0, 32'h8000_0000);
        queue_poll(3, 1'b0, 32'h8000_0032);
        queue_presses(150);
        wait_drained();

        // Zero debounce and zero press limit, all buttons active high.
        write_all(0, 0, 15, 15);
        queue_poll(3, 1'b1, 32'd400);
        queue_poll(3, 1'b0, 32'd450);
        queue_poll(3, 1'b1, 32'd500);
        queue_poll(3, 1'b1, 32'd500);
        queue_poll(3, 1'b0, 32'd500);
        queue_poll(3, 1'b0, 32'd501);
        queue_presses(100);
        wait_drained();

        // Widest times; every button disabled, then half of them.
        write_all(65535, 65535, 10, 0);
        for (int b = 0; b < NUM_BUTTONS_DEF; b++) queue_poll(b, 1'b1, $urandom());
        wait_drained();
        write_reg(CFG_ENABLE, 16'd5);
        queue_presses(150);
        hold_asks++;
        wait_drained();

        // Short times so that the exact debounce and limit boundaries come up often.
        write_all(3, 12, 6, 15);
        queue_presses(200);
        wait_drained();

        write_all($urandom_range(0, 200), $urandom_range(200, 2000),
                  $urandom_range(0, 15), $urandom_range(0, 15));
        queue_presses(150);
        wait_drained();

        pace_on = 1'b0;
        write_all(20, 200, 0, 15);
        queue_presses(150);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (outcome_q.size() != 0) begin
            $display("%0t: %0d results expected, actual none", $time, outcome_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
